### design/cfp_pkg.sv
// ----------------------------------------------------------------------------
// Response field parser package
// Character codes, field identifiers, the scan state and the match result
// shared by the parser modules.
// ----------------------------------------------------------------------------
package cfp_pkg;

   typedef logic [7:0] char_type;
   typedef logic [2:0] field_id_type;
   typedef logic [29:0] field_value_type;

   localparam char_type CHAR_NUL       = 8'h00;
   localparam char_type CHAR_SEMICOLON = 8'h3B;
   localparam char_type CHAR_ZERO      = 8'h30;
   localparam char_type CHAR_ONE       = 8'h31;
   localparam char_type CHAR_NINE      = 8'h39;
   localparam char_type CHAR_UPPER_A   = 8'h41;
   localparam char_type CHAR_UPPER_B   = 8'h42;
   localparam char_type CHAR_UPPER_D   = 8'h44;
   localparam char_type CHAR_UPPER_E   = 8'h45;
   localparam char_type CHAR_UPPER_F   = 8'h46;
   localparam char_type CHAR_UPPER_G   = 8'h47;
   localparam char_type CHAR_UPPER_M   = 8'h4D;
   localparam char_type CHAR_UPPER_P   = 8'h50;
   localparam char_type CHAR_UPPER_R   = 8'h52;
   localparam char_type CHAR_UPPER_T   = 8'h54;

   localparam logic [3:0] SHORT_MAX_DIGITS = 4'd9;
   localparam logic [1:0] LONG_MAX_DIGITS  = 2'd3;
   localparam logic [1:0] LAST_POSITION    = 2'd3;

   localparam field_id_type FIELD_VFO_A_FREQ = 3'd0;
   localparam field_id_type FIELD_VFO_B_FREQ = 3'd1;
   localparam field_id_type FIELD_AF_GAIN    = 3'd2;
   localparam field_id_type FIELD_RF_GAIN    = 3'd3;
   localparam field_id_type FIELD_MIC_GAIN   = 3'd4;
   localparam field_id_type FIELD_MODE       = 3'd5;
   localparam field_id_type FIELD_PREAMP     = 3'd6;
   localparam field_id_type FIELD_ACTIVE_VFO = 3'd7;

   typedef struct packed {
      logic [1:0]      position;
      char_type        prefix0;
      char_type        prefix1;
      char_type        prefix2;
      field_value_type short_value;
      logic [3:0]      short_count;
      logic            short_stopped;
      logic [9:0]      short_lead3;
      logic [3:0]      short_lead1;
      logic [9:0]      long_value;
      logic [1:0]      long_count;
      logic            long_stopped;
      logic [3:0]      long_lead1;
      char_type        mode_byte;
   } scan_state_type;

   typedef struct packed {
      logic            hit;
      field_id_type    field_id;
      field_value_type field_value;
   } match_type;

   function automatic logic [3:0] mode_code(input char_type c);
      char_type diff;
      diff = 8'd0;
      if (c inside {[CHAR_ONE:CHAR_NINE]}) begin
         diff = c - CHAR_ZERO;
      end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_E]}) begin
         diff = c - CHAR_UPPER_A + 8'd10;
      end
      return diff[3:0];
   endfunction

endpackage

### design/cat_response_field_parser.sv
// ----------------------------------------------------------------------------
// Response field parser
// Turns the received byte stream of a radio control link into field updates.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle while the input is not stalled. A
// byte passes through an input register and then updates the scan state; when
// the byte is the ';' that ends a recognized response, the result transaction
// goes from the input register through the result register onto the rsp_
// channel. A pending result that is stalled holds back the input only when the
// next byte would also produce a result.
module cat_response_field_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_field_id,
   output logic [29:0] rsp_field_value
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   cfp_pkg::char_type        in_byte_ff;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   cfp_pkg::field_id_type    out_id_ff;
   cfp_pkg::field_value_type out_value_ff;
   cfp_pkg::scan_state_type  scan_state;
   cfp_pkg::match_type       match;
   logic                     emit;
   logic                     out_free;
   logic                     fire;

   cfp_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .advance    (fire),
      .rx_byte    (in_byte_ff),
      .scan_state (scan_state)
   );

   cfp_match u_match (
      .scan_state (scan_state),
      .match      (match)
   );

   assign emit      = in_byte_ff == cfp_pkg::CHAR_SEMICOLON && match.hit;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !fire;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = (out_valid_ff && rsp_stall) || (fire && emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      if (fire && emit) begin
         out_id_ff    <= match.field_id;
         out_value_ff <= match.field_value;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_field_id    = out_id_ff;
   assign rsp_field_value = out_value_ff;

`ifndef ASSERT_OFF
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      fire && in_byte_ff == cfp_pkg::CHAR_SEMICOLON |=> scan_state.position == 2'd0)
      else $error("Scan state was not cleared after the end of a response.");

   a_result_only_at_end: assert property (@(posedge clock) disable iff (reset)
      fire && in_byte_ff != cfp_pkg::CHAR_SEMICOLON && !(out_valid_ff && rsp_stall)
      |=> !out_valid_ff)
      else $error("A result transaction appeared without an end of response.");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall && emit)
      else $error("Input stalled without a blocked result.");
`endif

endmodule

### design/cfp_scan.sv
// ----------------------------------------------------------------------------
// Response field parser scan state
// Holds the prefix bytes, the two digit runs and the mode byte of the response
// in progress and updates them with each accepted byte other than NUL.
// ----------------------------------------------------------------------------
module cfp_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  cfp_pkg::char_type       rx_byte,
   output cfp_pkg::scan_state_type scan_state
);

   cfp_pkg::scan_state_type scan_ff;
   cfp_pkg::scan_state_type scan_in;
   logic                    is_digit;
   logic [3:0]              digit;

   assign is_digit = rx_byte inside {[cfp_pkg::CHAR_ZERO:cfp_pkg::CHAR_NINE]};
   assign digit    = rx_byte[3:0];

   always_comb begin
      scan_in = scan_ff;
      if (rx_byte == cfp_pkg::CHAR_SEMICOLON) begin
         scan_in = '0;
      end else if (rx_byte != cfp_pkg::CHAR_NUL) begin
         case (scan_ff.position)
            2'd0: scan_in.prefix0 = rx_byte;
            2'd1: scan_in.prefix1 = rx_byte;
            2'd2: scan_in.prefix2 = rx_byte;
            default: ;
         endcase

         if (scan_ff.position >= 2'd2 && !scan_ff.short_stopped) begin
            if (is_digit && scan_ff.short_count < cfp_pkg::SHORT_MAX_DIGITS) begin
               scan_in.short_value = {scan_ff.short_value[26:0], 3'b000}
                                   + {scan_ff.short_value[28:0], 1'b0}
                                   + {26'd0, digit};
               scan_in.short_count = scan_ff.short_count + 4'd1;
               if (scan_ff.short_count < 4'd3) begin
                  scan_in.short_lead3 = {scan_ff.short_lead3[6:0], 3'b000}
                                      + {scan_ff.short_lead3[8:0], 1'b0}
                                      + {6'd0, digit};
               end
               if (scan_ff.short_count == 4'd0) begin
                  scan_in.short_lead1 = digit;
               end
            end else begin
               scan_in.short_stopped = 1'b1;
            end
         end

         if (scan_ff.position == cfp_pkg::LAST_POSITION) begin
            if (!scan_ff.long_stopped) begin
               if (is_digit && scan_ff.long_count < cfp_pkg::LONG_MAX_DIGITS) begin
                  scan_in.long_value = {scan_ff.long_value[6:0], 3'b000}
                                     + {scan_ff.long_value[8:0], 1'b0}
                                     + {6'd0, digit};
                  scan_in.long_count = scan_ff.long_count + 2'd1;
                  if (scan_ff.long_count == 2'd0) begin
                     scan_in.long_lead1 = digit;
                  end
               end else begin
                  scan_in.long_stopped = 1'b1;
               end
            end
            if (scan_ff.mode_byte == cfp_pkg::CHAR_NUL) begin
               scan_in.mode_byte = rx_byte;
            end
         end

         if (scan_ff.position != cfp_pkg::LAST_POSITION) begin
            scan_in.position = scan_ff.position + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else if (advance) begin
         scan_ff <= scan_in;
      end
   end

   assign scan_state = scan_ff;

endmodule

### design/cfp_match.sv
// ----------------------------------------------------------------------------
// Response field parser prefix match
// Compares the stored prefix against the known responses in priority order
// and selects the field identifier and value of the first one that matches.
// ----------------------------------------------------------------------------
module cfp_match (
   input  cfp_pkg::scan_state_type scan_state,
   output cfp_pkg::match_type       match
);

   logic short_ok;
   logic long_ok;
   logic p_fa, p_fb, p_ag0, p_rg0, p_mg, p_md0, p_pa0, p_ft;

   assign short_ok = scan_state.short_count != 4'd0;
   assign long_ok  = scan_state.long_count != 2'd0;

   assign p_fa  = scan_state.prefix0 == cfp_pkg::CHAR_UPPER_F
               && scan_state.prefix1 == cfp_pkg::CHAR_UPPER_A;
   assign p_fb  = scan_state.prefix0 == cfp_pkg::CHAR_UPPER_F
               && scan_state.prefix1 == cfp_pkg::CHAR_UPPER_B;
   assign p_ag0 = scan_state.prefix0 == cfp_pkg::CHAR_UPPER_A
               && scan_state.prefix1 == cfp_pkg::CHAR_UPPER_G
               && scan_state.prefix2 == cfp_pkg::CHAR_ZERO;
   assign p_rg0 = scan_state.prefix0 == cfp_pkg::CHAR_UPPER_R
               && scan_state.prefix1 == cfp_pkg::CHAR_UPPER_G
               && scan_state.prefix2 == cfp_pkg::CHAR_ZERO;
   assign p_mg  = scan_state.prefix0 == cfp_pkg::CHAR_UPPER_M
               && scan_state.prefix1 == cfp_pkg::CHAR_UPPER_G;
   assign p_md0 = scan_state.prefix0 == cfp_pkg::CHAR_UPPER_M
               && scan_state.prefix1 == cfp_pkg::CHAR_UPPER_D
               && scan_state.prefix2 == cfp_pkg::CHAR_ZERO;
   assign p_pa0 = scan_state.prefix0 == cfp_pkg::CHAR_UPPER_P
               && scan_state.prefix1 == cfp_pkg::CHAR_UPPER_A
               && scan_state.prefix2 == cfp_pkg::CHAR_ZERO;
   assign p_ft  = scan_state.prefix0 == cfp_pkg::CHAR_UPPER_F
               && scan_state.prefix1 == cfp_pkg::CHAR_UPPER_T;

   always_comb begin
      match = '0;
      if (p_fa && short_ok) begin
         match.hit         = 1'b1;
         match.field_id    = cfp_pkg::FIELD_VFO_A_FREQ;
         match.field_value = scan_state.short_value;
      end else if (p_fb && short_ok) begin
         match.hit         = 1'b1;
         match.field_id    = cfp_pkg::FIELD_VFO_B_FREQ;
         match.field_value = scan_state.short_value;
      end else if (p_ag0 && long_ok) begin
         match.hit         = 1'b1;
         match.field_id    = cfp_pkg::FIELD_AF_GAIN;
         match.field_value = {22'd0, scan_state.long_value[7:0]};
      end else if (p_rg0 && long_ok) begin
         match.hit         = 1'b1;
         match.field_id    = cfp_pkg::FIELD_RF_GAIN;
         match.field_value = {22'd0, scan_state.long_value[7:0]};
      end else if (p_mg && short_ok) begin
         match.hit         = 1'b1;
         match.field_id    = cfp_pkg::FIELD_MIC_GAIN;
         match.field_value = {22'd0, scan_state.short_lead3[7:0]};
      end else if (p_md0 && scan_state.mode_byte != cfp_pkg::CHAR_NUL) begin
         match.hit         = 1'b1;
         match.field_id    = cfp_pkg::FIELD_MODE;
         match.field_value = {26'd0, cfp_pkg::mode_code(scan_state.mode_byte)};
      end else if (p_pa0 && long_ok) begin
         match.hit         = 1'b1;
         match.field_id    = cfp_pkg::FIELD_PREAMP;
         match.field_value = {26'd0, scan_state.long_lead1};
      end else if (p_ft && short_ok) begin
         match.hit         = 1'b1;
         match.field_id    = cfp_pkg::FIELD_ACTIVE_VFO;
         match.field_value = {26'd0, scan_state.short_lead1};
      end
   end

endmodule

### tb/cfp_field_checker.sv
// ----------------------------------------------------------------------------
// Response field parser checker
// Watches the byte and result channels of the parser. It keeps its own scan of
// each response, queues each field update that an accepted ';' should give,
// and compares each result transaction with the oldest queued update.
// ----------------------------------------------------------------------------
module cfp_field_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_field_id,
   input  logic [29:0] rsp_field_value,
   output int          fail_count,
   output int          due_count,
   output int          checked_count
);

   typedef struct packed {
      cfp_pkg::field_id_type    id;
      cfp_pkg::field_value_type value;
   } field_update_type;

   logic [1:0]               scan_pos;
   cfp_pkg::char_type        head_chars [3];
   cfp_pkg::field_value_type freq_value;
   logic [3:0]               freq_digits;
   logic                     freq_done;
   logic [9:0]               gain_value;
   logic [1:0]               gain_digits;
   logic                     gain_done;
   cfp_pkg::char_type        mode_byte;

   field_update_type         updates_due [$];
   field_update_type         oldest;
   int                       errors = 0;
   int                       checked = 0;

   function automatic bit is_numeral(input cfp_pkg::char_type c);
      return c >= cfp_pkg::CHAR_ZERO && c <= cfp_pkg::CHAR_NINE;
   endfunction

   function automatic int unsigned first_digits(input int unsigned v, input int unsigned n,
                                                input int unsigned keep);
      while (n > keep) begin
         v = v / 10;
         n--;
      end
      return v;
   endfunction

   function automatic logic [3:0] mode_number(input cfp_pkg::char_type c);
      int unsigned code;
      code = 0;
      if (c >= cfp_pkg::CHAR_ONE && c <= cfp_pkg::CHAR_NINE) begin
         code = c - cfp_pkg::CHAR_ZERO;
      end else if (c >= cfp_pkg::CHAR_UPPER_A && c <= cfp_pkg::CHAR_UPPER_E) begin
         code = c - cfp_pkg::CHAR_UPPER_A + 10;
      end
      return code[3:0];
   endfunction

   function automatic bit starts_with(input cfp_pkg::char_type a, input cfp_pkg::char_type b);
      return head_chars[0] == a && head_chars[1] == b;
   endfunction

   function automatic bit starts_with3(input cfp_pkg::char_type a, input cfp_pkg::char_type b,
                                       input cfp_pkg::char_type c);
      return head_chars[0] == a && head_chars[1] == b && head_chars[2] == c;
   endfunction

   task automatic clear_scan();
      scan_pos = 2'd0;
      foreach (head_chars[i]) head_chars[i] = cfp_pkg::CHAR_NUL;
      freq_value = '0;
      freq_digits = '0;
      freq_done = 1'b0;
      gain_value = '0;
      gain_digits = '0;
      gain_done = 1'b0;
      mode_byte = cfp_pkg::CHAR_NUL;
   endtask

   task automatic take_char(input cfp_pkg::char_type c);
      field_update_type upd;
      bit hit;
      int unsigned acc;
      if (c == cfp_pkg::CHAR_NUL) return;
      if (c == cfp_pkg::CHAR_SEMICOLON) begin
         hit = 1'b1;
         upd = '0;
         if (starts_with(cfp_pkg::CHAR_UPPER_F, cfp_pkg::CHAR_UPPER_A)
             && freq_digits != 4'd0) begin
            upd.id = cfp_pkg::FIELD_VFO_A_FREQ;
            upd.value = freq_value;
         end else if (starts_with(cfp_pkg::CHAR_UPPER_F, cfp_pkg::CHAR_UPPER_B)
                      && freq_digits != 4'd0) begin
            upd.id = cfp_pkg::FIELD_VFO_B_FREQ;
            upd.value = freq_value;
         end else if (starts_with3(cfp_pkg::CHAR_UPPER_A, cfp_pkg::CHAR_UPPER_G,
                                   cfp_pkg::CHAR_ZERO) && gain_digits != 2'd0) begin
            upd.id = cfp_pkg::FIELD_AF_GAIN;
            upd.value = {22'd0, gain_value[7:0]};
         end else if (starts_with3(cfp_pkg::CHAR_UPPER_R, cfp_pkg::CHAR_UPPER_G,
                                   cfp_pkg::CHAR_ZERO) && gain_digits != 2'd0) begin
            upd.id = cfp_pkg::FIELD_RF_GAIN;
            upd.value = {22'd0, gain_value[7:0]};
         end else if (starts_with(cfp_pkg::CHAR_UPPER_M, cfp_pkg::CHAR_UPPER_G)
                      && freq_digits != 4'd0) begin
            upd.id = cfp_pkg::FIELD_MIC_GAIN;
            upd.value = cfp_pkg::field_value_type'(
               first_digits(32'(freq_value), 32'(freq_digits), 3) & 32'hFF);
         end else if (starts_with3(cfp_pkg::CHAR_UPPER_M, cfp_pkg::CHAR_UPPER_D,
                                   cfp_pkg::CHAR_ZERO) && mode_byte != cfp_pkg::CHAR_NUL) begin
            upd.id = cfp_pkg::FIELD_MODE;
            upd.value = {26'd0, mode_number(mode_byte)};
         end else if (starts_with3(cfp_pkg::CHAR_UPPER_P, cfp_pkg::CHAR_UPPER_A,
                                   cfp_pkg::CHAR_ZERO) && gain_digits != 2'd0) begin
            upd.id = cfp_pkg::FIELD_PREAMP;
            upd.value = cfp_pkg::field_value_type'(
               first_digits(32'(gain_value), 32'(gain_digits), 1));
         end else if (starts_with(cfp_pkg::CHAR_UPPER_F, cfp_pkg::CHAR_UPPER_T)
                      && freq_digits != 4'd0) begin
            upd.id = cfp_pkg::FIELD_ACTIVE_VFO;
            upd.value = cfp_pkg::field_value_type'(
               first_digits(32'(freq_value), 32'(freq_digits), 1));
         end else begin
            hit = 1'b0;
         end
         if (hit) updates_due.push_back(upd);
         clear_scan();
         return;
      end
      if (scan_pos < cfp_pkg::LAST_POSITION) head_chars[scan_pos] = c;
      if (scan_pos >= 2'd2 && !freq_done) begin
         if (is_numeral(c) && freq_digits < cfp_pkg::SHORT_MAX_DIGITS) begin
            acc = freq_value * 10 + (c - cfp_pkg::CHAR_ZERO);
            freq_value = acc[29:0];
            freq_digits++;
         end else begin
            freq_done = 1'b1;
         end
      end
      if (scan_pos == cfp_pkg::LAST_POSITION) begin
         if (!gain_done) begin
            if (is_numeral(c) && gain_digits < cfp_pkg::LONG_MAX_DIGITS) begin
               acc = gain_value * 10 + (c - cfp_pkg::CHAR_ZERO);
               gain_value = acc[9:0];
               gain_digits++;
            end else begin
               gain_done = 1'b1;
            end
         end
         if (mode_byte == cfp_pkg::CHAR_NUL) mode_byte = c;
      end
      if (scan_pos < cfp_pkg::LAST_POSITION) scan_pos++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         updates_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (updates_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, got id %0d value %0d",
                        $time, rsp_field_id, rsp_field_value);
               errors++;
            end else begin
               oldest = updates_due.pop_front();
               checked++;
               if (rsp_field_id !== oldest.id) begin
                  $display("%0t: field id mismatch, expected %0d, got %0d",
                           $time, oldest.id, rsp_field_id);
                  errors++;
               end
               if (rsp_field_value !== oldest.value) begin
                  $display("%0t: field value mismatch (id %0d), expected %0d, got %0d",
                           $time, oldest.id, oldest.value, rsp_field_value);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) take_char(req_rx_byte);
      end
      fail_count <= errors;
      due_count <= updates_due.size();
      checked_count <= checked;
   end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Response field parser testbench
// Feeds the parser a directed set of responses, a long random mix of
// well-formed, near-miss and noisy responses, and a burst sent while the
// result side is held off. Both sides idle at random; the checker compares
// every result transaction and the top reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int GAP_MAX      = 12;
   localparam int HOLD_CYCLES  = 250;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_BYTES = 440;
   localparam int DRAIN_CYCLES = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_field_id;
   logic [29:0] rsp_field_value;

   int          fail_count;
   int          due_count;
   int          checked_count;

   cfp_pkg::char_type stream_q [$];
   int          bytes_sent = 0;
   int          responses_built = 0;
   int          send_run = 0;
   int          recv_run = 0;
   int          idle_cycles = 0;
   bit          hold_results = 1'b0;

   always #6 clock = ~clock;

   cat_response_field_parser DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_field_id    (rsp_field_id),
      .rsp_field_value (rsp_field_value)
   );

   cfp_field_checker field_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_field_id    (rsp_field_id),
      .rsp_field_value (rsp_field_value),
      .fail_count      (fail_count),
      .due_count       (due_count),
      .checked_count   (checked_count)
   );

   function automatic int draw_gap(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         run_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, GAP_MAX);
   endfunction

   function automatic string prefix_of(input cfp_pkg::field_id_type id);
      case (id)
         cfp_pkg::FIELD_VFO_A_FREQ: return "FA";
         cfp_pkg::FIELD_VFO_B_FREQ: return "FB";
         cfp_pkg::FIELD_AF_GAIN:    return "AG0";
         cfp_pkg::FIELD_RF_GAIN:    return "RG0";
         cfp_pkg::FIELD_MIC_GAIN:   return "MG";
         cfp_pkg::FIELD_MODE:       return "MD0";
         cfp_pkg::FIELD_PREAMP:     return "PA0";
         default:                   return "FT";
      endcase
   endfunction

   task automatic push_char(input cfp_pkg::char_type c, input bit sprinkle);
      if (sprinkle && $urandom_range(0, 24) == 0) stream_q.push_back(cfp_pkg::CHAR_NUL);
      stream_q.push_back(c);
      if (c == cfp_pkg::CHAR_SEMICOLON) responses_built++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
   endtask

   task automatic add_random_response();
      string near_chars;
      string head;
      string lead_junk;
      string mode_symbols;
      int kind;
      int ndig;
      bit nines;
      cfp_pkg::char_type c;
      near_chars = "FABGRMDPT0";
      lead_junk = " +-\t";
      mode_symbols = "123456789ABCDE";
      kind = $urandom_range(0, 11);
      if (kind == 11) begin
         repeat ($urandom_range(1, 6))
            push_char(cfp_pkg::char_type'($urandom_range(0, 255)), 1'b0);
         return;
      end
      if (kind <= 7) begin
         head = prefix_of(cfp_pkg::field_id_type'(kind));
         for (int i = 0; i < head.len(); i++) push_char(head[i], 1'b1);
      end else begin
         repeat ($urandom_range(2, 3))
            push_char(near_chars[$urandom_range(0, near_chars.len() - 1)], 1'b1);
      end
      if ($urandom_range(0, 9) == 0)
         push_char(lead_junk[$urandom_range(0, lead_junk.len() - 1)], 1'b1);
      if (kind == int'(cfp_pkg::FIELD_MODE)) begin
         if ($urandom_range(0, 7) != 0) begin
            if ($urandom_range(0, 1) == 1) begin
               c = mode_symbols[$urandom_range(0, mode_symbols.len() - 1)];
            end else begin
               c = cfp_pkg::char_type'($urandom_range(1, 255));
            end
            push_char(c, 1'b1);
         end
      end else begin
         ndig = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 11);
         nines = ($urandom_range(0, 5) == 0);
         repeat (ndig) begin
            c = nines ? cfp_pkg::CHAR_NINE
                      : cfp_pkg::char_type'(cfp_pkg::CHAR_ZERO + $urandom_range(0, 9));
            push_char(c, 1'b1);
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            c = cfp_pkg::char_type'($urandom_range(1, 255));
            if (c == cfp_pkg::CHAR_SEMICOLON) c = cfp_pkg::CHAR_UPPER_T;
            push_char(c, 1'b1);
         end
      end
      push_char(cfp_pkg::CHAR_SEMICOLON, 1'b0);
   endtask

   task automatic send_stream(input bit eager);
      int gap;
      cfp_pkg::char_type c;
      while (stream_q.size() > 0) begin
         c = stream_q.pop_front();
         gap = eager ? 0 : draw_gap(send_run);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_rx_byte <= c;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         bytes_sent++;
      end
   endtask

   initial begin
      int gap;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = draw_gap(recv_run);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      push_text("FA999999999;");
      push_text("FB0;");
      push_text("AG0255;");
      push_text("RG0999;");
      push_text("MG1234;");
      push_text("MD0E;");
      push_text("MD01;");
      push_text("MD0~;");
      push_text("MD0;");
      push_text("PA0123;");
      push_text("FT98;");
      push_text("FA 12;");
      push_text("FB-7;");
      push_text("FA12kHz;");
      push_text("XY5;");
      push_text("FA;");
      push_char(cfp_pkg::CHAR_UPPER_F, 1'b0);
      push_char(cfp_pkg::CHAR_NUL, 1'b0);
      push_char(cfp_pkg::CHAR_UPPER_A, 1'b0);
      push_text("4");
      push_char(cfp_pkg::CHAR_NUL, 1'b0);
      push_text("2;");
      push_char(8'hFF, 1'b0);
      push_char(8'h80, 1'b0);
      push_char(cfp_pkg::CHAR_SEMICOLON, 1'b0);
      send_stream(1'b0);

      while (stream_q.size() < RANDOM_BYTES / 2) add_random_response();
      send_stream(1'b0);

      hold_results = 1'b1;
      repeat (40) begin
         push_text("FT");
         push_char(cfp_pkg::char_type'(cfp_pkg::CHAR_ZERO + $urandom_range(0, 9)), 1'b0);
         push_char(cfp_pkg::CHAR_SEMICOLON, 1'b0);
      end
      send_stream(1'b1);

      while (stream_q.size() < RANDOM_BYTES / 2) add_random_response();
      send_stream(1'b0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d bytes in %0d responses, with a burst against a held result side.",
               bytes_sent, responses_built);
      $display("%0d field updates were compared, with %0d mismatches.", checked_count, fail_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
design/cfp_pkg.sv
design/cfp_scan.sv
design/cfp_match.sv
design/cat_response_field_parser.sv
tb/cfp_field_checker.sv
tb/tb_top.sv
